/* hw/rtl/wtpc_pkg.sv */
// Shared types, register indexes and fixed-point helpers for the world-to-pixel covariance block.
`default_nettype none
package wtpc_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_XY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y    = 3'd6;

  localparam logic [47:0] ROT_ROW0_RST = 48'h0000_0000_4000;
  localparam logic [47:0] ROT_ROW1_RST = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_ROW2_RST = 48'h4000_0000_0000;
  localparam logic [31:0] FOCAL_RST    = 32'd32768000;

  localparam logic signed [63:0] Q16_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q16_MIN = -64'sd2147483648;
  localparam logic signed [31:0] Q16_ONE = 32'sd65536;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    logic [2:0][47:0] rot;
    logic [63:0]      org_xy;
    logic [31:0]      org_z;
    logic [31:0]      fx;
    logic [31:0]      fy;
  } cfg_t;

  typedef struct packed {
    q16_t v;
    logic f;
  } sat_t;

  typedef struct packed {
    q16_t             pc_x;
    q16_t             pc_y;
    q16_t             pc_z;
    logic [5:0][31:0] sc;
    logic             sat;
    logic             zero;
  } geo_t;

  typedef struct packed {
    q16_t             j00;
    q16_t             j11;
    logic [5:0][31:0] sc;
    logic             sat;
    logic             zero;
  } jac_t;

  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    r.f = 1'b1;
    if (x > Q16_MAX) begin
      r.v = 32'sh7fffffff;
    end else if (x < Q16_MIN) begin
      r.v = 32'sh80000000;
    end else begin
      r.v = x[31:0];
      r.f = 1'b0;
    end
    return r;
  endfunction

  // Arithmetic right shift that rounds half up.
  function automatic logic signed [63:0] rshr(input logic signed [63:0] x,
                                              input int unsigned n);
    logic signed [63:0] half;
    half = 64'sd1 <<< (n - 1);
    return (x + half) >>> n;
  endfunction

  function automatic logic signed [15:0] rot_at(input cfg_t c, input int unsigned k,
                                                input int unsigned i);
    return $signed(c.rot[k][16*i +: 16]);
  endfunction

  // Slot of a symmetric 3x3 entry in the packed upper triangle.
  function automatic int unsigned sidx(input int unsigned i, input int unsigned k);
    int unsigned r;
    r = 0;
    case ({i[1:0], k[1:0]})
      4'b0000: r = 0;
      4'b0001: r = 1;
      4'b0100: r = 1;
      4'b0010: r = 2;
      4'b1000: r = 2;
      4'b0101: r = 3;
      4'b0110: r = 4;
      4'b1001: r = 4;
      4'b1010: r = 5;
      default: r = 0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/world_to_pixel_covariance.sv */
// Top level of the world-to-pixel covariance pipeline with its register bank.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_stall    point x,y,z and six covariance entries
//   out_     output     out_valid / out_stall  uu, uv, vv, depth flag, saturation flag
//   cfg_     input      cfg_we                 register index and 64-bit data
//
// One beat is accepted every cycle while in_stall is low.
// Most of the pipeline depth lies in the two rows of 33-step pipelined dividers for the Jacobian.
// Reset clears all valid bits and loads the register bank with its defaults.
// A stalled output beat holds the whole pipeline, so nothing is lost or repeated.
`default_nettype none
module world_to_pixel_covariance (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [31:0]                   in_point_x,
  input  logic signed [31:0]                   in_point_y,
  input  logic signed [31:0]                   in_point_z,
  input  logic signed [31:0]                   in_cov_xx,
  input  logic signed [31:0]                   in_cov_xy,
  input  logic signed [31:0]                   in_cov_xz,
  input  logic signed [31:0]                   in_cov_yy,
  input  logic signed [31:0]                   in_cov_yz,
  input  logic signed [31:0]                   in_cov_zz,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [31:0]                   out_pix_cov_uu,
  output logic signed [31:0]                   out_pix_cov_uv,
  output logic signed [31:0]                   out_pix_cov_vv,
  output logic                                 out_depth_near_zero,
  output logic                                 out_saturated,
  input  logic                                 cfg_we,
  input  logic [wtpc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [63:0]                          cfg_wdata
);
  import wtpc_pkg::*;

  cfg_t             cfg_r;
  logic             adv;
  q16_t [2:0]       pt;
  q16_t [5:0]       cov;
  logic             x_v;
  geo_t             geo;
  logic             d1_v;
  q16_t             j00, j11;
  logic             j00_f, j11_f;
  logic [$bits(geo_t)-1:0] geo_bits;
  geo_t             geo1;
  logic             jm_v_r;
  logic signed [63:0] nx_r, ny_r;
  q16_t             den_r;
  jac_t             jac_r;
  logic             d2_v;
  q16_t             j02, j12;
  logic             j02_f, j12_f;
  logic [$bits(jac_t)-1:0] jac_bits;
  jac_t             jac2;
  logic             p_v;
  q16_t             uu, uv, vv;
  logic             p_zero, p_sat;

  assign adv      = !(p_v && out_stall);
  assign in_stall = p_v && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot[0] <= ROT_ROW0_RST;
      cfg_r.rot[1] <= ROT_ROW1_RST;
      cfg_r.rot[2] <= ROT_ROW2_RST;
      cfg_r.org_xy <= '0;
      cfg_r.org_z  <= '0;
      cfg_r.fx     <= FOCAL_RST;
      cfg_r.fy     <= FOCAL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ROT_ROW0:  cfg_r.rot[0] <= cfg_wdata[47:0];
        CFG_ROT_ROW1:  cfg_r.rot[1] <= cfg_wdata[47:0];
        CFG_ROT_ROW2:  cfg_r.rot[2] <= cfg_wdata[47:0];
        CFG_ORIGIN_XY: cfg_r.org_xy <= cfg_wdata;
        CFG_ORIGIN_Z:  cfg_r.org_z  <= cfg_wdata[31:0];
        CFG_FOCAL_X:   cfg_r.fx     <= cfg_wdata[31:0];
        CFG_FOCAL_Y:   cfg_r.fy     <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign pt[0]  = in_point_x;
  assign pt[1]  = in_point_y;
  assign pt[2]  = in_point_z;
  assign cov[0] = in_cov_xx;
  assign cov[1] = in_cov_xy;
  assign cov[2] = in_cov_xz;
  assign cov[3] = in_cov_yy;
  assign cov[4] = in_cov_yz;
  assign cov[5] = in_cov_zz;

  wtpc_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .cfg       (cfg_r),
    .pt        (pt),
    .cov       (cov),
    .out_valid (x_v),
    .geo       (geo)
  );

  wtpc_div #(.NUM_W(49), .SB_W($bits(geo_t))) u_div_fx (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (x_v),
    .num       ($signed({1'b0, cfg_r.fx, 16'd0})),
    .den       (geo.pc_z),
    .sb_in     (geo),
    .out_valid (d1_v),
    .q         (j00),
    .q_sat     (j00_f),
    .sb_out    (geo_bits)
  );

  wtpc_div #(.NUM_W(49), .SB_W(1)) u_div_fy (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (x_v),
    .num       ($signed({1'b0, cfg_r.fy, 16'd0})),
    .den       (geo.pc_z),
    .sb_in     (1'b0),
    .out_valid (),
    .q         (j11),
    .q_sat     (j11_f),
    .sb_out    ()
  );

  assign geo1 = geo_t'(geo_bits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jm_v_r <= 1'b0;
    end else if (adv) begin
      jm_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r      <= -(64'(j00) * 64'($signed(geo1.pc_x)));
      ny_r      <= -(64'(j11) * 64'($signed(geo1.pc_y)));
      den_r     <= geo1.pc_z;
      jac_r.j00 <= j00;
      jac_r.j11 <= j11;
      jac_r.sc  <= geo1.sc;
      jac_r.sat <= geo1.sat | j00_f | j11_f;
      jac_r.zero <= geo1.zero;
    end
  end

  wtpc_div #(.NUM_W(64), .SB_W($bits(jac_t))) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (jm_v_r),
    .num       (nx_r),
    .den       (den_r),
    .sb_in     (jac_r),
    .out_valid (d2_v),
    .q         (j02),
    .q_sat     (j02_f),
    .sb_out    (jac_bits)
  );

  wtpc_div #(.NUM_W(64), .SB_W(1)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (jm_v_r),
    .num       (ny_r),
    .den       (den_r),
    .sb_in     (1'b0),
    .out_valid (),
    .q         (j12),
    .q_sat     (j12_f),
    .sb_out    ()
  );

  assign jac2 = jac_t'(jac_bits);

  wtpc_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (d2_v),
    .jb        (jac2),
    .j02       (j02),
    .j12       (j12),
    .sat_in    (jac2.sat | j02_f | j12_f),
    .out_valid (p_v),
    .uu        (uu),
    .uv        (uv),
    .vv        (vv),
    .zero      (p_zero),
    .sat       (p_sat)
  );

  assign out_valid           = p_v;
  assign out_pix_cov_uu      = uu;
  assign out_pix_cov_uv      = uv;
  assign out_pix_cov_vv      = vv;
  assign out_depth_near_zero = p_zero;
  assign out_saturated       = p_sat;

endmodule
`default_nettype wire

/* hw/rtl/wtpc_xform.sv */
// Camera-frame point and rotated covariance, five register stages.
`default_nettype none
module wtpc_xform (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  wtpc_pkg::cfg_t        cfg,
  input  wtpc_pkg::q16_t [2:0]  pt,
  input  wtpc_pkg::q16_t [5:0]  cov,
  output logic                  out_valid,
  output wtpc_pkg::geo_t        geo
);
  import wtpc_pkg::*;

  logic [4:0]         v_r;
  logic signed [32:0] d_r      [3];
  logic signed [32:0] d_nxt    [3];
  q16_t               cov_r    [6];
  logic signed [50:0] pcacc_r  [3];
  logic signed [50:0] pcacc_nxt[3];
  logic signed [49:0] macc_r   [9];
  logic signed [49:0] macc_nxt [9];
  q16_t               pc_r     [3];
  q16_t               pc_nxt   [3];
  logic               pcf_r;
  logic               pcf_nxt;
  logic signed [35:0] m_r      [9];
  logic signed [35:0] m_nxt    [9];
  logic signed [53:0] scacc_r  [6];
  logic signed [53:0] scacc_nxt[6];
  q16_t               pc4_r    [3];
  logic               pcf4_r;
  geo_t               geo_r;
  geo_t               geo_nxt;

  always_comb begin
    d_nxt[0] = 33'($signed(pt[0])) - 33'($signed(cfg.org_xy[31:0]));
    d_nxt[1] = 33'($signed(pt[1])) - 33'($signed(cfg.org_xy[63:32]));
    d_nxt[2] = 33'($signed(pt[2])) - 33'($signed(cfg.org_z));
  end

  always_comb begin
    logic signed [63:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int k = 0; k < 3; k++) begin
        acc = acc + 64'(rot_at(cfg, k, i)) * 64'(d_r[k]);
      end
      pcacc_nxt[i] = 51'(acc);
    end
    for (int i = 0; i < 3; i++) begin
      for (int l = 0; l < 3; l++) begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          acc = acc + 64'($signed(cov_r[sidx(i, k)])) * 64'(rot_at(cfg, k, l));
        end
        macc_nxt[i*3+l] = 50'(acc);
      end
    end
  end

  always_comb begin
    sat_t s;
    pcf_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s = sat32(rshr(64'(pcacc_r[i]), 14));
      pc_nxt[i] = s.v;
      pcf_nxt = pcf_nxt | s.f;
    end
    for (int n = 0; n < 9; n++) begin
      m_nxt[n] = 36'(rshr(64'(macc_r[n]), 14));
    end
  end

  always_comb begin
    logic signed [63:0] acc;
    acc = '0;
    for (int n = 0; n < 6; n++) begin
      scacc_nxt[n] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int l = 0; l < 3; l++) begin
        if (l >= i) begin
          acc = '0;
          for (int k = 0; k < 3; k++) begin
            acc = acc + 64'(rot_at(cfg, k, i)) * 64'(m_r[k*3+l]);
          end
          scacc_nxt[sidx(i, l)] = 54'(acc);
        end
      end
    end
  end

  always_comb begin
    sat_t s;
    geo_nxt.pc_x = pc4_r[0];
    geo_nxt.pc_y = pc4_r[1];
    geo_nxt.pc_z = pc4_r[2];
    geo_nxt.zero = (pc4_r[2] == '0);
    geo_nxt.sat  = pcf4_r;
    for (int n = 0; n < 6; n++) begin
      s = sat32(rshr(64'(scacc_r[n]), 14));
      geo_nxt.sc[n] = s.v;
      geo_nxt.sat = geo_nxt.sat | s.f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]     <= d_nxt[i];
        pcacc_r[i] <= pcacc_nxt[i];
        pc_r[i]    <= pc_nxt[i];
        pc4_r[i]   <= pc_r[i];
      end
      for (int n = 0; n < 6; n++) begin
        cov_r[n]   <= cov[n];
        scacc_r[n] <= scacc_nxt[n];
      end
      for (int n = 0; n < 9; n++) begin
        macc_r[n] <= macc_nxt[n];
        m_r[n]    <= m_nxt[n];
      end
      pcf_r  <= pcf_nxt;
      pcf4_r <= pcf_r;
      geo_r  <= geo_nxt;
    end
  end

  assign out_valid = v_r[4];
  assign geo       = geo_r;

endmodule
`default_nettype wire

/* hw/rtl/wtpc_div.sv */
// Pipelined rounding divider, one quotient bit per stage, saturated to Q16.16.
`default_nettype none
module wtpc_div #(
  parameter int unsigned NUM_W = 49,
  parameter int unsigned SB_W  = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [NUM_W-1:0] num,
  input  wtpc_pkg::q16_t          den,
  input  logic [SB_W-1:0]         sb_in,
  output logic                    out_valid,
  output wtpc_pkg::q16_t          q,
  output logic                    q_sat,
  output logic [SB_W-1:0]         sb_out
);
  import wtpc_pkg::*;

  localparam int unsigned QW = 33;

  logic [31:0]     rem_r [QW+1];
  logic [QW-1:0]   nq_r  [QW+1];
  logic [31:0]     ud_r  [QW+1];
  logic            neg_r [QW+1];
  logic            big_r [QW+1];
  logic            v_r   [QW+1];
  logic [SB_W-1:0] sb_r  [QW+1];

  logic [NUM_W-1:0] un;
  logic [31:0]      ud;
  logic [NUM_W:0]   n;
  logic [63:0]      hi;

  logic            fin_v_r;
  q16_t            fin_q_r;
  logic            fin_f_r;
  logic [SB_W-1:0] fin_sb_r;
  logic            ov;
  q16_t            q_nxt;

  always_comb begin
    un = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    ud = den[31] ? 32'(-den) : 32'(den);
    n  = (NUM_W+1)'(un) + (NUM_W+1)'(ud >> 1);
    hi = 64'(n >> QW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= hi[31:0];
      nq_r[0]  <= n[QW-1:0];
      ud_r[0]  <= ud;
      neg_r[0] <= num[NUM_W-1] ^ den[31];
      big_r[0] <= (hi >= {32'd0, ud});
      sb_r[0]  <= sb_in;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [32:0] t;
    logic        ge;
    assign t  = {rem_r[s-1], nq_r[s-1][QW-1]};
    assign ge = (t >= {1'b0, ud_r[s-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= ge ? 32'(t - {1'b0, ud_r[s-1]}) : t[31:0];
        nq_r[s]  <= {nq_r[s-1][QW-2:0], ge};
        ud_r[s]  <= ud_r[s-1];
        neg_r[s] <= neg_r[s-1];
        big_r[s] <= big_r[s-1];
        sb_r[s]  <= sb_r[s-1];
      end
    end
  end

  always_comb begin
    if (neg_r[QW]) begin
      ov    = big_r[QW] | (nq_r[QW] > 33'h0_8000_0000);
      q_nxt = ov ? 32'sh80000000 : 32'(-nq_r[QW]);
    end else begin
      ov    = big_r[QW] | (nq_r[QW] > 33'h0_7fff_ffff);
      q_nxt = ov ? 32'sh7fffffff : nq_r[QW][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (adv) begin
      fin_v_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_q_r  <= q_nxt;
      fin_f_r  <= ov;
      fin_sb_r <= sb_r[QW];
    end
  end

  assign out_valid = fin_v_r;
  assign q         = fin_q_r;
  assign q_sat     = fin_f_r;
  assign sb_out    = fin_sb_r;

endmodule
`default_nettype wire

/* hw/rtl/wtpc_proj.sv */
// Projection of the camera covariance through the Jacobian, four register stages.
`default_nettype none
module wtpc_proj (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  wtpc_pkg::jac_t jb,
  input  wtpc_pkg::q16_t j02,
  input  wtpc_pkg::q16_t j12,
  input  logic           sat_in,
  output logic           out_valid,
  output wtpc_pkg::q16_t uu,
  output wtpc_pkg::q16_t uv,
  output wtpc_pkg::q16_t vv,
  output logic           zero,
  output logic           sat
);
  import wtpc_pkg::*;

  logic [3:0]         v_r;
  logic signed [63:0] a0_r[3], b0_r[3], a1_r[3], b1_r[3];
  q16_t               j00_1_r, j02_1_r, j11_1_r, j12_1_r;
  q16_t               j00_2_r, j02_2_r, j11_2_r, j12_2_r;
  logic               f1_r, z1_r, f2_r, z2_r, f3_r, z3_r;
  q16_t               t0_r[3], t1_r[3];
  q16_t               t0_nxt[3], t1_nxt[3];
  logic               tf_nxt;
  logic signed [63:0] pu0_r, pu1_r, pm0_r, pm1_r, pv0_r, pv1_r;
  q16_t               uu_r, uv_r, vv_r;
  logic               zero_r, sat_r;
  sat_t               su, sm, sv;

  always_comb begin
    sat_t s0, s1;
    tf_nxt = 1'b0;
    for (int l = 0; l < 3; l++) begin
      s0 = sat32(rshr(a0_r[l], 16) + rshr(b0_r[l], 16));
      s1 = sat32(rshr(a1_r[l], 16) + rshr(b1_r[l], 16));
      t0_nxt[l] = s0.v;
      t1_nxt[l] = s1.v;
      tf_nxt = tf_nxt | s0.f | s1.f;
    end
  end

  always_comb begin
    su = sat32(rshr(pu0_r, 16) + rshr(pu1_r, 16));
    sm = sat32(rshr(pm0_r, 16) + rshr(pm1_r, 16));
    sv = sat32(rshr(pv0_r, 16) + rshr(pv1_r, 16));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        a0_r[l] <= 64'($signed(jb.j00)) * 64'($signed(jb.sc[sidx(0, l)]));
        b0_r[l] <= 64'($signed(j02))    * 64'($signed(jb.sc[sidx(2, l)]));
        a1_r[l] <= 64'($signed(jb.j11)) * 64'($signed(jb.sc[sidx(1, l)]));
        b1_r[l] <= 64'($signed(j12))    * 64'($signed(jb.sc[sidx(2, l)]));
        t0_r[l] <= t0_nxt[l];
        t1_r[l] <= t1_nxt[l];
      end
      j00_1_r <= jb.j00;
      j02_1_r <= j02;
      j11_1_r <= jb.j11;
      j12_1_r <= j12;
      f1_r    <= sat_in;
      z1_r    <= jb.zero;

      j00_2_r <= j00_1_r;
      j02_2_r <= j02_1_r;
      j11_2_r <= j11_1_r;
      j12_2_r <= j12_1_r;
      f2_r    <= f1_r | tf_nxt;
      z2_r    <= z1_r;

      pu0_r <= 64'(t0_r[0]) * 64'(j00_2_r);
      pu1_r <= 64'(t0_r[2]) * 64'(j02_2_r);
      pm0_r <= 64'(t0_r[1]) * 64'(j11_2_r);
      pm1_r <= 64'(t0_r[2]) * 64'(j12_2_r);
      pv0_r <= 64'(t1_r[1]) * 64'(j11_2_r);
      pv1_r <= 64'(t1_r[2]) * 64'(j12_2_r);
      f3_r  <= f2_r;
      z3_r  <= z2_r;

      if (z3_r) begin
        uu_r  <= Q16_ONE;
        uv_r  <= '0;
        vv_r  <= Q16_ONE;
        sat_r <= 1'b0;
      end else begin
        uu_r  <= su.v;
        uv_r  <= sm.v;
        vv_r  <= sv.v;
        sat_r <= f3_r | su.f | sm.f | sv.f;
      end
      zero_r <= z3_r;
    end
  end

  assign out_valid = v_r[3];
  assign uu        = uu_r;
  assign uv        = uv_r;
  assign vv        = vv_r;
  assign zero      = zero_r;
  assign sat       = sat_r;

endmodule
`default_nettype wire

/* hw/rtl/wtpc_chk.sv */
// Port-level checker for the world-to-pixel covariance block and its bind.
`default_nettype none
module wtpc_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [31:0]             out_pix_cov_uu,
  input logic signed [31:0]             out_pix_cov_uv,
  input logic signed [31:0]             out_pix_cov_vv,
  input logic                           out_depth_near_zero,
  input logic                           out_saturated
);
  import wtpc_pkg::*;

  a_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pix_cov_uu)
      && $stable(out_pix_cov_uv) && $stable(out_pix_cov_vv))
    else $error("stalled output beat changed");

  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_depth_near_zero |-> out_pix_cov_uu == Q16_ONE
      && out_pix_cov_uv == 0 && out_pix_cov_vv == Q16_ONE && !out_saturated)
    else $error("zero-depth beat is not the identity");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind world_to_pixel_covariance wtpc_chk u_wtpc_chk (.*);
`default_nettype wire
